// ===== src/erp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package erp_pkg;

    // parser mode
    typedef enum logic [1:0] {
        MODE_SKIP = 2'd0,
        MODE_REC  = 2'd1,
        MODE_ESC1 = 2'd2,
        MODE_ESC2 = 2'd3
    } parse_mode_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_CHAR      = 3'd0,
        ST_REC_END   = 3'd1,
        ST_ESC_ERR   = 3'd2,
        ST_EOI_IDLE  = 3'd3,
        ST_EOI_CLOSE = 3'd4
    } status_t;

    localparam logic [15:0] CH_PCT   = 16'h0025;
    localparam logic [15:0] CH_COMMA = 16'h002C;
    localparam logic [15:0] CH_NL    = 16'h000A;
    localparam logic [15:0] CH_CR    = 16'h000D;
    localparam logic [15:0] CH_TAB   = 16'h0009;
    localparam logic [15:0] CH_SP    = 16'h0020;
    localparam logic [15:0] CH_0     = 16'h0030;
    localparam logic [15:0] CH_9     = 16'h0039;
    localparam logic [15:0] CH_LA    = 16'h0061;
    localparam logic [15:0] CH_LF    = 16'h0066;
    localparam logic [15:0] CH_UA    = 16'h0041;
    localparam logic [15:0] CH_UF    = 16'h0046;

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

    // parser state carried from beat to beat
    typedef struct packed {
        parse_mode_t  mode;
        logic [4:0]   first_digit;
        logic [15:0]  char_count;
        logic [23:0]  line_count;
    } parser_state_t;

    // one result beat
    typedef struct packed {
        status_t      status;
        logic [15:0]  ch;
        logic [23:0]  line;
    } result_t;

    function automatic logic is_blank(input logic [15:0] c);
        return c inside {CH_SP, CH_TAB, CH_NL, CH_CR};
    endfunction

    function automatic logic is_delim(input logic [15:0] c);
        return c inside {CH_COMMA, CH_NL, CH_CR};
    endfunction

    // bit 4 flags a hex digit, bits 3..0 hold its value
    function automatic logic [4:0] hex_val(input logic [15:0] c);
        logic [15:0] d;
        d = 16'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            return {1'b1, d[3:0]};
        end
        if (c >= CH_LA && c <= CH_LF) begin
            d = c - CH_LA + 16'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + 16'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

`default_nettype wire

// ===== src/erp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module erp_step (
    input  erp_pkg::parser_state_t cur,
    input  logic [15:0]            c,
    input  logic                   eoi,
    input  logic [15:0]            limit,
    output erp_pkg::parser_state_t nxt,
    output logic                   has_result,
    output erp_pkg::result_t       result
);

    logic [15:0] cnt;
    logic [4:0]  d2;
    logic [7:0]  esc_val;
    logic [23:0] line_next;

    // every newline outside end of input advances the line count, saturating at LINE_MAX
    always_comb
    begin
        line_next = cur.line_count;
        if (!eoi && c == erp_pkg::CH_NL && cur.line_count != erp_pkg::LINE_MAX) begin
            line_next = cur.line_count + 24'd1;
        end
    end

    // escape value from the two digits
    always_comb
    begin
        d2 = erp_pkg::hex_val(c);
        esc_val = 8'd0;
        if (cur.first_digit[4]) begin
            if (d2[4]) begin
                esc_val = {cur.first_digit[3:0], d2[3:0]};
            end else begin
                esc_val = {4'd0, cur.first_digit[3:0]};
            end
        end
    end

    // next state and result
    always_comb
    begin
        nxt = cur;
        nxt.line_count = line_next;
        has_result = 1'b0;
        result.status = erp_pkg::ST_CHAR;
        result.ch = 16'd0;
        result.line = line_next;
        cnt = (cur.mode == erp_pkg::MODE_SKIP) ? 16'd0 : cur.char_count;

        if (eoi) begin
            has_result = 1'b1;
            if (cur.mode == erp_pkg::MODE_SKIP) begin
                result.status = erp_pkg::ST_EOI_IDLE;
            end else begin
                result.status = erp_pkg::ST_EOI_CLOSE;
                nxt.mode = erp_pkg::MODE_SKIP;
                nxt.char_count = 16'd0;
                nxt.first_digit = 5'd0;
            end
        end else begin
            case (cur.mode)
                erp_pkg::MODE_SKIP, erp_pkg::MODE_REC:
                begin
                    if (cur.mode == erp_pkg::MODE_SKIP && erp_pkg::is_blank(c)) begin
                        has_result = 1'b0;
                    end else if (erp_pkg::is_delim(c) || cnt >= limit) begin
                        has_result = 1'b1;
                        result.status = erp_pkg::ST_REC_END;
                        nxt.mode = erp_pkg::MODE_SKIP;
                        nxt.char_count = 16'd0;
                        nxt.first_digit = 5'd0;
                    end else if (c == erp_pkg::CH_PCT) begin
                        nxt.mode = erp_pkg::MODE_ESC1;
                        nxt.first_digit = 5'd0;
                        nxt.char_count = cnt;
                    end else begin
                        has_result = 1'b1;
                        result.ch = c;
                        nxt.mode = erp_pkg::MODE_REC;
                        nxt.char_count = cnt + 16'd1;
                    end
                end
                erp_pkg::MODE_ESC1:
                begin
                    if (erp_pkg::is_delim(c)) begin
                        has_result = 1'b1;
                        result.status = erp_pkg::ST_ESC_ERR;
                        nxt.mode = erp_pkg::MODE_SKIP;
                        nxt.char_count = 16'd0;
                        nxt.first_digit = 5'd0;
                    end else begin
                        nxt.first_digit = d2;
                        nxt.mode = erp_pkg::MODE_ESC2;
                    end
                end
                default:
                begin
                    has_result = 1'b1;
                    nxt.first_digit = 5'd0;
                    if (erp_pkg::is_delim(c)) begin
                        result.status = erp_pkg::ST_ESC_ERR;
                        nxt.mode = erp_pkg::MODE_SKIP;
                        nxt.char_count = 16'd0;
                    end else begin
                        result.ch = {8'd0, esc_val};
                        nxt.mode = erp_pkg::MODE_REC;
                        nxt.char_count = cur.char_count + 16'd1;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/escaped_record_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Escaped record parser: splits a 16-bit character stream into records at
// comma, LF and CR, skips leading blanks, decodes %XX escapes and keeps a
// saturating line count.
// Input channel: in_valid / in_stall with in_char and end_of_input.
// Output channel: out_valid / out_stall with status, out_char, line_number.
// An input beat gives zero or one output beat (blanks while idle, '%' below the
// record limit and a first escape digit other than a delimiter give none).
// A beat accepted into the input register is parsed into the result register,
// from which its result is offered.
// Throughput: one beat per cycle while the receiver does not stall; the loop
// through the parser state register sets it.
// When the receiver stalls, the result register holds and the input
// register holds its beat; in_stall rises only while both are full.
// cfg_write loads the record length limit (clamped to MAX_RECORD_LENGTH);
// write it only while the block is idle.
// Reset: parser skipping blanks, line count 1, limit MAX_RECORD_LENGTH,
// both registers empty.
module escaped_record_parser_unit #(
    parameter int unsigned MAX_RECORD_LENGTH = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] in_char,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] out_char,
    output logic [23:0] line_number
);

    localparam logic [15:0] MAX_LIM = MAX_RECORD_LENGTH[15:0];

    logic                   in_valid_reg;
    logic [15:0]            in_char_reg;
    logic                   eoi_reg;
    logic [15:0]            limit_reg;
    erp_pkg::parser_state_t state_reg;
    erp_pkg::parser_state_t state_next;
    logic                   out_valid_reg;
    erp_pkg::result_t       result_reg;
    erp_pkg::result_t       result_next;
    logic                   has_result;
    logic                   advance;

    // input beat moves on when the result register has room
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // effective limit, clamped at write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_reg <= MAX_LIM;
        end else if (cfg_write) begin
            limit_reg <= (cfg_data > MAX_LIM) ? MAX_LIM : cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid) begin
            in_char_reg <= in_char;
            eoi_reg     <= end_of_input;
        end
    end

    erp_step u_step (
        .cur        (state_reg),
        .c          (in_char_reg),
        .eoi        (eoi_reg),
        .limit      (limit_reg),
        .nxt        (state_next),
        .has_result (has_result),
        .result     (result_next)
    );

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.mode        <= erp_pkg::MODE_SKIP;
            state_reg.first_digit <= 5'd0;
            state_reg.char_count  <= 16'd0;
            state_reg.line_count  <= 24'd1;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result) begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = result_reg.status;
    assign out_char    = result_reg.ch;
    assign line_number = result_reg.line;

`ifndef NO_ASSERTIONS
    // line count never goes backward
    a_line_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> state_reg.line_count >= $past(state_reg.line_count))
        else $error("line count decreased");

    // idle parser holds no record residue
    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode == erp_pkg::MODE_SKIP |->
            (state_reg.char_count == 16'd0 && state_reg.first_digit == 5'd0))
        else $error("idle parser holds record state");

    // non-character results carry a zero character
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.status != erp_pkg::ST_CHAR) |->
            result_reg.ch == 16'd0)
        else $error("non-character result with data");

    // empty result register never stalls the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import erp_pkg::*;

    localparam int MAX_LEN = 32768;

    typedef enum int {ROW_BEAT, ROW_TYPED, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] val;
        logic        eoi;
        result_t     want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] in_char;
    logic        end_of_input;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [15:0] out_char;
    logic [23:0] line_number;

    // tags riding along with the input beat for directed rows
    logic        row_typed;
    result_t     row_want;

    // parser model state
    parse_mode_t pm_mode;
    logic [4:0]  pm_digit;
    logic [15:0] pm_count;
    logic [23:0] pm_line;
    logic [15:0] pm_limit;

    result_t     pending_results[$];
    stim_row_t   directed_rows[$];

    int fail_count = 0;
    int n_beats = 0;
    int n_results = 0;
    int n_rec_end = 0;
    int n_esc_err = 0;
    int n_eoi = 0;
    int n_cfg = 0;
    int cur_limit = MAX_LEN;
    int stall_left = 0;
    logic calm = 1'b0;

    escaped_record_parser_unit #(
        .MAX_RECORD_LENGTH(MAX_LEN)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_char     (in_char),
        .end_of_input(end_of_input),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_char    (out_char),
        .line_number (line_number)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("tb_top: timeout, results still pending: %0d", pending_results.size());
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic blank_char(input logic [15:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
    endfunction

    function automatic logic delim_char(input logic [15:0] c);
        return (c == CH_COMMA) || (c == CH_NL) || (c == CH_CR);
    endfunction

    // {is hex, value}; the low nibble of 'a'..'f' and 'A'..'F' is value - 9
    function automatic logic [4:0] digit_of(input logic [15:0] c);
        if (c >= CH_0 && c <= CH_9)
            return {1'b1, c[3:0]};
        if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF))
            return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    task automatic count_newline(input logic [15:0] c);
        if (c == CH_NL && pm_line != LINE_MAX)
            pm_line = pm_line + 24'd1;
    endtask

    task automatic drop_record();
        pm_mode  = MODE_SKIP;
        pm_count = 16'd0;
        pm_digit = 5'd0;
    endtask

    // advance the parser model by one beat
    task automatic parse_beat(input logic [15:0] c, input logic eoi,
                              output logic got, output result_t r);
        logic [4:0] d2;
        int lim;
        got      = 1'b1;
        r.status = ST_CHAR;
        r.ch     = 16'd0;
        lim      = (pm_limit > MAX_LEN) ? MAX_LEN : int'(pm_limit);
        if (eoi)
        begin
            if (pm_mode == MODE_SKIP)
                r.status = ST_EOI_IDLE;
            else
            begin
                r.status = ST_EOI_CLOSE;
                drop_record();
            end
        end
        else if (pm_mode == MODE_SKIP && blank_char(c))
        begin
            count_newline(c);
            got = 1'b0;
        end
        else if (pm_mode == MODE_SKIP || pm_mode == MODE_REC)
        begin
            if (pm_mode == MODE_SKIP)
                pm_count = 16'd0;
            if (delim_char(c) || pm_count >= lim)
            begin
                count_newline(c);
                drop_record();
                r.status = ST_REC_END;
            end
            else if (c == CH_PCT)
            begin
                pm_mode  = MODE_ESC1;
                pm_digit = 5'd0;
                got      = 1'b0;
            end
            else
            begin
                pm_mode  = MODE_REC;
                pm_count = pm_count + 16'd1;
                r.ch     = c;
            end
        end
        else if (delim_char(c))
        begin
            count_newline(c);
            drop_record();
            r.status = ST_ESC_ERR;
        end
        else if (pm_mode == MODE_ESC1)
        begin
            pm_digit = digit_of(c);
            pm_mode  = MODE_ESC2;
            got      = 1'b0;
        end
        else
        begin
            d2 = digit_of(c);
            if (pm_digit[4])
                r.ch = d2[4] ? {8'd0, pm_digit[3:0], d2[3:0]} : {12'd0, pm_digit[3:0]};
            pm_digit = 5'd0;
            pm_mode  = MODE_REC;
            pm_count = pm_count + 16'd1;
        end
        r.line = pm_line;
    endtask

    task automatic flag(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // scoreboard: check result beats, predict accepted input beats
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        logic got;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                pm_limit = cfg_data;
                n_cfg++;
            end
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (status == ST_REC_END)
                    n_rec_end++;
                if (status == ST_ESC_ERR)
                    n_esc_err++;
                if (status == ST_EOI_IDLE || status == ST_EOI_CLOSE)
                    n_eoi++;
                if (pending_results.size() == 0)
                    flag($sformatf("tb_top: unexpected beat status %0d char %h line %0d",
                                   status, out_char, line_number));
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status || out_char !== want.ch
                        || line_number !== want.line)
                        flag($sformatf({"tb_top: beat %0d mismatch, want/got: status %0d/%0d",
                                        " char %h/%h line %0d/%0d"}, n_results,
                                       want.status, status, want.ch, out_char,
                                       want.line, line_number));
                end
            end
            if (in_valid && !in_stall)
            begin
                n_beats++;
                parse_beat(in_char, end_of_input, got, want);
                if (row_typed)
                begin
                    want = row_want;
                    got  = 1'b1;
                end
                if (got)
                    pending_results.push_back(want);
            end
        end
    end

    // receiver stall pattern: mostly short stalls, a few long ones
    always @(posedge clk)
    begin : stall_gen
        int r;
        r = $urandom_range(0, 99);
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (calm || r < 50)
        begin
            out_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
        else if (r < 90)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else if (r < 98)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(3, 11);
        end
        else
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(29, 79);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // offer one beat and hold it until accepted
    task automatic send_beat(input logic [15:0] c, input logic eoi,
                             input logic typed, input result_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_char      <= c;
        end_of_input <= eoi;
        row_typed    <= typed;
        row_want     <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop sending until every result is back and the pipe has drained
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_limit(input logic [15:0] v);
        wait_quiet();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_limit = v;
    endtask

    function automatic logic [15:0] pick_digit();
        int r;
        int v;
        r = $urandom_range(0, 99);
        v = $urandom_range(0, 15);
        if (r < 85)
        begin
            if (v < 10)
                return CH_0 + 16'(v);
            return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 16'(v - 10);
        end
        case ($urandom_range(0, 6))
            0: return CH_0 - 16'd1;
            1: return CH_9 + 16'd1;
            2: return CH_UA - 16'd1;
            3: return CH_UF + 16'd1;
            4: return CH_LA - 16'd1;
            5: return CH_LF + 16'd1;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_plain();
        logic [15:0] c;
        if ($urandom_range(0, 99) < 30)
            return 16'($urandom());
        c = 16'($urandom_range(16'h0021, 16'h007E));
        if (c == CH_PCT || c == CH_COMMA)
            c = CH_LF + 16'd5;
        return c;
    endfunction

    // record break: a delimiter or an end-of-input mark
    task automatic send_break();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_beat(CH_COMMA, 1'b0, 1'b0, '0);
        else if (r < 65)
            send_beat(CH_NL, 1'b0, 1'b0, '0);
        else if (r < 80)
            send_beat(CH_CR, 1'b0, 1'b0, '0);
        else
            send_beat(16'($urandom()), 1'b1, 1'b0, '0);
    endtask

    // one record, sometimes overlong, with some non-hex escape digits, or broken inside an escape
    task automatic send_record();
        int n;
        int r;
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0: send_beat(CH_SP, 1'b0, 1'b0, '0);
                1: send_beat(CH_TAB, 1'b0, 1'b0, '0);
                2: send_beat(CH_NL, 1'b0, 1'b0, '0);
                default: send_beat(CH_CR, 1'b0, 1'b0, '0);
            endcase
        end
        if (cur_limit <= 8 && $urandom_range(0, 1))
            n = $urandom_range(cur_limit, cur_limit + 2);
        else
            n = $urandom_range(0, 6);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 75)
                send_beat(pick_plain(), 1'b0, 1'b0, '0);
            else
            begin
                send_beat(CH_PCT, 1'b0, 1'b0, '0);
                r = $urandom_range(0, 99);
                if (r < 5)
                begin
                    send_break();
                    return;
                end
                send_beat(pick_digit(), 1'b0, 1'b0, '0);
                if (r < 10)
                begin
                    send_break();
                    return;
                end
                send_beat(pick_digit(), 1'b0, 1'b0, '0);
            end
        end
        if ($urandom_range(0, 9) != 0)
            send_break();
    endtask

    // stray beats: random characters, specials, end marks
    task automatic send_noise();
        int n;
        int r;
        n = $urandom_range(1, 5);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_beat(16'($urandom()), 1'b0, 1'b0, '0);
            else if (r < 85)
            begin
                case ($urandom_range(0, 6))
                    0: send_beat(CH_SP, 1'b0, 1'b0, '0);
                    1: send_beat(CH_TAB, 1'b0, 1'b0, '0);
                    2: send_beat(CH_NL, 1'b0, 1'b0, '0);
                    3: send_beat(CH_CR, 1'b0, 1'b0, '0);
                    4: send_beat(CH_COMMA, 1'b0, 1'b0, '0);
                    5: send_beat(CH_PCT, 1'b0, 1'b0, '0);
                    default: send_beat(pick_digit(), 1'b0, 1'b0, '0);
                endcase
            end
            else
                send_beat(16'($urandom()), 1'b1, 1'b0, '0);
        end
    endtask

    function automatic void add_row(input row_kind_t kind, input logic [15:0] val,
                                    input logic eoi, input status_t st,
                                    input logic [15:0] ch, input logic [23:0] ln);
        stim_row_t row;
        row.kind        = kind;
        row.val         = val;
        row.eoi         = eoi;
        row.want.status = st;
        row.want.ch     = ch;
        row.want.line   = ln;
        directed_rows.push_back(row);
    endfunction

    // stimulus
    initial
    begin : stimulus
        int phase;
        int target;
        int r;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_data     = 16'd0;
        in_valid     = 1'b0;
        in_char      = 16'd0;
        end_of_input = 1'b0;
        out_stall    = 1'b0;
        row_typed    = 1'b0;
        row_want     = '0;
        pm_mode      = MODE_SKIP;
        pm_digit     = 5'd0;
        pm_count     = 16'd0;
        pm_line      = 24'd1;
        pm_limit     = 16'(MAX_LEN);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // end mark while idle, blanks, empty record, extreme characters
        add_row(ROW_TYPED, 16'd0, 1'b1, ST_EOI_IDLE, 16'd0, 24'd1);
        add_row(ROW_BEAT, CH_SP, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, CH_TAB, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, CH_NL, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_TYPED, CH_COMMA, 1'b0, ST_REC_END, 16'd0, 24'd2);
        add_row(ROW_TYPED, 16'hFFFF, 1'b0, ST_CHAR, 16'hFFFF, 24'd2);
        add_row(ROW_TYPED, 16'h0000, 1'b0, ST_CHAR, 16'h0000, 24'd2);
        // full escape, then non-hex second and first digits
        add_row(ROW_BEAT, CH_PCT, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, CH_UA, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_TYPED, CH_LF, 1'b0, ST_CHAR, 16'h00AF, 24'd2);
        add_row(ROW_BEAT, CH_PCT, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, CH_9, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, CH_UF + 16'd1, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, CH_PCT, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, 16'h007A, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, CH_0 + 16'd5, 1'b0, ST_CHAR, 16'd0, 24'd0);
        // delimiters inside an escape, end mark inside an escape
        add_row(ROW_BEAT, CH_PCT, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_TYPED, CH_COMMA, 1'b0, ST_ESC_ERR, 16'd0, 24'd2);
        add_row(ROW_BEAT, CH_PCT, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, CH_0 + 16'd3, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_TYPED, CH_NL, 1'b0, ST_ESC_ERR, 16'd0, 24'd3);
        add_row(ROW_BEAT, CH_PCT, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_TYPED, 16'd0, 1'b1, ST_EOI_CLOSE, 16'd0, 24'd3);
        // smallest limit: second character dropped, escape counts as one
        add_row(ROW_CFG, 16'd1, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, CH_LA + 16'd1, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_TYPED, CH_LA + 16'd2, 1'b0, ST_REC_END, 16'd0, 24'd3);
        add_row(ROW_BEAT, CH_PCT, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, CH_0 + 16'd4, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_BEAT, CH_0 + 16'd1, 1'b0, ST_CHAR, 16'd0, 24'd0);
        add_row(ROW_TYPED, CH_PCT, 1'b0, ST_REC_END, 16'd0, 24'd3);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                load_limit(directed_rows[i].val);
            else
                send_beat(directed_rows[i].val, directed_rows[i].eoi,
                          directed_rows[i].kind == ROW_TYPED, directed_rows[i].want);
        end

        // random phases, each under its own record limit
        target = n_beats + 750;
        phase  = 0;
        while (n_beats < target)
        begin
            r = $urandom_range(0, 99);
            case (phase)
                0: load_limit(16'h8000);
                1: load_limit(16'd1);
                2: load_limit(16'd2);
                default:
                begin
                    if (r < 30)
                        load_limit(16'($urandom_range(1, 6)));
                    else if (r < 60)
                        load_limit(16'($urandom_range(7, 40)));
                    else if (r < 80)
                        load_limit(16'h8000);
                    else
                        load_limit(16'($urandom_range(1, 32768)));
                end
            endcase
            calm = (phase % 3 == 2);
            repeat (20)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_record();
                else
                    send_noise();
            end
            phase++;
        end
        calm = 1'b0;

        // drain
        wait_quiet();
        repeat (6) @(posedge clk);
        while (pending_results.size() != 0)
        begin
            result_t left;
            left = pending_results.pop_front();
            flag($sformatf("tb_top: missing beat status %0d char %h line %0d",
                           left.status, left.ch, left.line));
        end

        $display("tb_top: %0d input beats, %0d results checked, %0d limit writes",
                 n_beats, n_results, n_cfg);
        $display("tb_top: %0d record ends, %0d escape errors, %0d end marks, %0d failures",
                 n_rec_end, n_esc_err, n_eoi, fail_count);
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
